// ===== sv/snzi_pkg.sv =====
// Package for the nonzero indicator counter tree: sizes, status codes and
// sequencer states. Used by nonzero_indicator_counter_tree; depends on nothing.
package snzi_pkg;

	localparam int LEAVES      = 8;
	localparam int COUNT_WIDTH = 16;
	localparam int NODE_TOTAL  = 2 * LEAVES - 1;
	localparam int LEAF_W      = $clog2(LEAVES);
	localparam int NODE_W      = $clog2(NODE_TOTAL);
	localparam int TID_W       = 10;
	localparam int CHG_W       = 31;

	localparam logic [COUNT_WIDTH-1:0] COUNT_FULL = '1;

	typedef logic [COUNT_WIDTH-1:0] count_t;
	typedef logic [NODE_W-1:0]      node_idx_t;

	typedef enum logic [1:0] {
		ST_OK          = 2'd0,
		ST_DEPART_ZERO = 2'd1,
		ST_FULL        = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_CHECK,
		S_INC,
		S_DEC,
		S_RESP
	} seq_state_t;

endpackage

// ===== sv/nonzero_indicator_counter_tree.sv =====
// Nonzero indicator counter tree: heap-ordered surplus counters walked by one
// shared increment/decrement unit under a small sequencer. Depends on snzi_pkg.
//
//  channel | direction | handshake           | payload
//  in      | input     | in_valid / in_stall   | cmd, thread_id
//  out     | output    | out_valid / out_stall | nonzero, change_count, status
//
// An arrival is first checked upward from its leaf (S_CHECK) and then
// incremented upward (S_INC); a departure is decremented upward from its leaf
// (S_DEC). Both end in S_RESP. One counter read-modify-write per cycle goes
// through the single adder. in_stall is high from acceptance until the result
// is loaded into the output register; a finished result waits in the output
// register while the next request is taken. Reset clears every counter, the
// indicator and the change counter at once.
module nonzero_indicator_counter_tree (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic                       cmd,
	input  logic [snzi_pkg::TID_W-1:0] thread_id,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic                       nonzero,
	output logic [snzi_pkg::CHG_W-1:0] change_count,
	output logic [1:0]                 status
);
	import snzi_pkg::*;

	seq_state_t        state_q, state_d;
	count_t            node_q [NODE_TOTAL];
	node_idx_t         idx_q, idx_d;
	node_idx_t         leaf_q, leaf_d;
	logic              first_q, first_d;
	status_t           stat_q, stat_d;
	logic              ind_q, ind_d;
	logic [CHG_W-1:0]  chg_q, chg_d;
	logic              out_valid_q;
	logic              nonzero_q;
	logic [CHG_W-1:0]  chg_out_q;
	status_t           status_q;

	count_t            cnt;
	count_t            sum;
	node_idx_t         parent;
	node_idx_t         leaf_node;
	logic              node_we;
	logic              out_load;

	// shared counter unit: read current node, step by one either way
	assign cnt       = node_q[idx_q];
	assign sum       = cnt + ((state_q == S_DEC) ? COUNT_FULL : count_t'(1));
	assign parent    = (idx_q - node_idx_t'(1)) >> 1;
	assign leaf_node = node_idx_t'(LEAVES - 1) + node_idx_t'(thread_id[LEAF_W-1:0]);

	// sequencer register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and walk control
	always_comb begin
		state_d  = state_q;
		idx_d    = idx_q;
		leaf_d   = leaf_q;
		first_d  = first_q;
		stat_d   = stat_q;
		ind_d    = ind_q;
		chg_d    = chg_q;
		node_we  = 1'b0;
		out_load = 1'b0;
		in_stall = (state_q != S_IDLE);
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					idx_d   = leaf_node;
					leaf_d  = leaf_node;
					first_d = 1'b1;
					stat_d  = ST_OK;
					state_d = cmd ? S_DEC : S_CHECK;
				end
			end
			S_CHECK: begin
				// reject before any change if the arrival path holds a full counter
				if (cnt == COUNT_FULL) begin
					stat_d  = ST_FULL;
					state_d = S_RESP;
				end else if (cnt != '0 || idx_q == '0) begin
					idx_d   = leaf_q;
					state_d = S_INC;
				end else begin
					idx_d = parent;
				end
			end
			S_INC: begin
				node_we = 1'b1;
				if (cnt != '0) begin
					state_d = S_RESP;
				end else if (idx_q == '0) begin
					ind_d   = 1'b1;
					chg_d   = chg_q + CHG_W'(1);
					state_d = S_RESP;
				end else begin
					idx_d = parent;
				end
			end
			S_DEC: begin
				first_d = 1'b0;
				if (cnt == '0) begin
					// leaf at zero: ignore; parent at zero: stop the walk
					stat_d  = first_q ? ST_DEPART_ZERO : ST_OK;
					state_d = S_RESP;
				end else begin
					node_we = 1'b1;
					if (sum != '0) begin
						state_d = S_RESP;
					end else if (idx_q == '0) begin
						ind_d   = 1'b0;
						chg_d   = chg_q + CHG_W'(1);
						state_d = S_RESP;
					end else begin
						idx_d = parent;
					end
				end
			end
			S_RESP: begin
				// hand the result over once the output register is free
				if (!out_valid_q || !out_stall) begin
					out_load = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// counters, indicator and walk registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NODE_TOTAL; i++) begin
				node_q[i] <= '0;
			end
			ind_q   <= 1'b0;
			chg_q   <= '0;
			idx_q   <= '0;
			leaf_q  <= '0;
			first_q <= 1'b0;
			stat_q  <= ST_OK;
		end else begin
			if (node_we) begin
				node_q[idx_q] <= sum;
			end
			ind_q   <= ind_d;
			chg_q   <= chg_d;
			idx_q   <= idx_d;
			leaf_q  <= leaf_d;
			first_q <= first_d;
			stat_q  <= stat_d;
		end
	end

	// output register: hold while stalled, drop once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			nonzero_q <= ind_q;
			chg_out_q <= chg_q;
			status_q  <= stat_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign nonzero      = nonzero_q;
	assign change_count = chg_out_q;
	assign status       = status_q;

	// indicator always mirrors the root counter
	a_ind_root: assert property (@(posedge clk) disable iff (!arst_n)
		ind_q == (node_q[0] != '0))
		else $error("indicator disagrees with root counter");

	// every indicator change bumps the change counter by one
	a_chg_bump: assert property (@(posedge clk) disable iff (!arst_n)
		(ind_q != $past(ind_q)) |-> (chg_q == CHG_W'($past(chg_q) + CHG_W'(1))))
		else $error("indicator changed without change count step");

	// change counter moves only with the indicator
	a_chg_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(ind_q == $past(ind_q)) |-> (chg_q == $past(chg_q)))
		else $error("change count moved without indicator change");

	// walk index stays inside the tree
	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> (idx_q < node_idx_t'(NODE_TOTAL)))
		else $error("walk index outside tree");

endmodule

// ===== sim/tb_nonzero_indicator_counter_tree.sv =====
// Self-checking bench for nonzero_indicator_counter_tree: directed table, random
// arrive/depart traffic and a back-to-back probe of one leaf, scored by a tree
// predictor. Depends on snzi_pkg and the block itself.
`timescale 1ns / 1ps

module tb_nonzero_indicator_counter_tree;
	import snzi_pkg::*;

	localparam logic CMD_ARRIVE    = 1'b0;
	localparam logic CMD_DEPART    = 1'b1;
	localparam int   RANDOM_ITEMS  = 1000;
	localparam int   BACKLOG_HOLD  = 300;
	localparam int   PROBE_LEAF    = 5;
	localparam int   DRAIN_CYCLES  = 24;
	localparam int   DIRECTED_ROWS = 23;

	typedef struct packed {
		logic             nonzero;
		logic [CHG_W-1:0] change_count;
		status_t          status;
	} tree_result_t;

	typedef struct packed {
		logic             cmd;
		logic [TID_W-1:0] tid;
		logic             typed;
		tree_result_t     want;
	} stim_row_t;

	logic             clk = 1'b0;
	logic             arst_n;
	logic             in_valid;
	logic             in_stall;
	logic             cmd;
	logic [TID_W-1:0] thread_id;
	logic             out_valid;
	logic             out_stall;
	logic             nonzero;
	logic [CHG_W-1:0] change_count;
	logic [1:0]       status;

	// predictor state: counters in heap order, indicator, transition count
	count_t           tree_counts [NODE_TOTAL];
	logic             tree_set;
	logic [CHG_W-1:0] tree_changes;

	tree_result_t pending_results [$];
	int           mismatches = 0;
	bit           steady     = 1'b0;
	bit           backlog_req = 1'b0;

	// Directed requests; typed rows carry a result read straight off the tree rules
	stim_row_t directed_rows [DIRECTED_ROWS] = '{
		'{CMD_DEPART, 10'd0,    1'b1, '{1'b0, 31'd0, ST_DEPART_ZERO}},
		'{CMD_ARRIVE, 10'd0,    1'b1, '{1'b1, 31'd1, ST_OK}},
		'{CMD_DEPART, 10'd0,    1'b1, '{1'b0, 31'd2, ST_OK}},
		'{CMD_ARRIVE, 10'd1023, 1'b1, '{1'b1, 31'd3, ST_OK}},
		'{CMD_ARRIVE, 10'd7,    1'b1, '{1'b1, 31'd3, ST_OK}},
		'{CMD_DEPART, 10'd8,    1'b1, '{1'b1, 31'd3, ST_DEPART_ZERO}},
		'{CMD_ARRIVE, 10'h155,  1'b0, '0},
		'{CMD_ARRIVE, 10'h2aa,  1'b0, '0},
		'{CMD_ARRIVE, 10'd1,    1'b0, '0},
		'{CMD_ARRIVE, 10'd3,    1'b0, '0},
		'{CMD_ARRIVE, 10'd4,    1'b0, '0},
		'{CMD_ARRIVE, 10'd6,    1'b0, '0},
		'{CMD_ARRIVE, 10'd0,    1'b0, '0},
		'{CMD_DEPART, 10'd1023, 1'b0, '0},
		'{CMD_DEPART, 10'd15,   1'b0, '0},
		'{CMD_DEPART, 10'd15,   1'b0, '0},
		'{CMD_DEPART, 10'd0,    1'b0, '0},
		'{CMD_DEPART, 10'd1,    1'b0, '0},
		'{CMD_DEPART, 10'h2aa,  1'b0, '0},
		'{CMD_DEPART, 10'd3,    1'b0, '0},
		'{CMD_DEPART, 10'd4,    1'b0, '0},
		'{CMD_DEPART, 10'h155,  1'b0, '0},
		'{CMD_DEPART, 10'd6,    1'b0, '0}
	};

	nonzero_indicator_counter_tree u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.cmd          (cmd),
		.thread_id    (thread_id),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.nonzero      (nonzero),
		.change_count (change_count),
		.status       (status)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 0;
	end

	// Mostly short gaps, now and then a long one
	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(99);
		if (roll < 50) return 0;
		if (roll < 85) return $urandom_range(1, 3);
		if (roll < 97) return $urandom_range(4, 10);
		return $urandom_range(20, 40);
	endfunction

	// Apply one request to the predicted tree and return the result it reports
	function automatic tree_result_t apply_request(logic op, logic [TID_W-1:0] tid);
		int           node;
		int           start;
		count_t       was;
		status_t      st;
		tree_result_t res;
		start = LEAVES - 1 + (tid % LEAVES);
		st = ST_OK;
		if (op == CMD_ARRIVE) begin
			// reject before touching anything if the walk would hit a full counter
			node = start;
			while (1) begin
				if (tree_counts[node] == COUNT_FULL) begin
					st = ST_FULL;
					break;
				end
				if (tree_counts[node] != 0 || node == 0) break;
				node = (node - 1) / 2;
			end
			node = start;
			while (st == ST_OK) begin
				was = tree_counts[node];
				tree_counts[node] = was + 1'b1;
				if (was != 0) break;
				if (node == 0) begin
					tree_set = 1'b1;
					tree_changes = tree_changes + 1'b1;
					break;
				end
				node = (node - 1) / 2;
			end
		end else if (tree_counts[start] == 0) begin
			st = ST_DEPART_ZERO;
		end else begin
			// walk upward while counters drop to zero
			node = start;
			while (1) begin
				tree_counts[node] = tree_counts[node] - 1'b1;
				if (tree_counts[node] != 0) break;
				if (node == 0) begin
					tree_set = 1'b0;
					tree_changes = tree_changes + 1'b1;
					break;
				end
				node = (node - 1) / 2;
				if (tree_counts[node] == 0) break;
			end
		end
		res.nonzero      = tree_set;
		res.change_count = tree_changes;
		res.status       = st;
		return res;
	endfunction

	// Offer one request, hold it until taken, then log its expected result
	task automatic send_request(input logic op, input logic [TID_W-1:0] tid,
			input logic typed, input tree_result_t want);
		int           gap;
		tree_result_t got;
		gap = steady ? 0 : pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid  <= 1'b1;
		cmd       <= op;
		thread_id <= tid;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		got = apply_request(op, tid);
		pending_results.push_back(typed ? want : got);
	endtask

	// Receiver: random stalls, calm stretches and one long backlog hold
	initial begin
		int hold;
		out_stall <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (backlog_req) begin
				backlog_req = 1'b0;
				hold = BACKLOG_HOLD;
			end else if (steady) begin
				hold = 0;
			end else begin
				hold = pick_gap();
			end
			if (hold > 0) begin
				out_stall <= 1'b1;
				repeat (hold) @(posedge clk);
			end
			out_stall <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
	end

	// Score every accepted result against the oldest expectation
	always @(posedge clk) begin
		tree_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				mismatches++;
				$display("%0t: result with no request pending", $time);
			end else begin
				want = pending_results.pop_front();
				if (nonzero !== want.nonzero) begin
					mismatches++;
					$display("%0t: nonzero expected %0d actual %0d",
						$time, want.nonzero, nonzero);
				end
				if (change_count !== want.change_count) begin
					mismatches++;
					$display("%0t: change_count expected %0d actual %0d",
						$time, want.change_count, change_count);
				end
				if (status !== want.status) begin
					mismatches++;
					$display("%0t: status expected %0d actual %0d",
						$time, want.status, status);
				end
			end
		end
	end

	// Main sequence: reset, directed table, random traffic, probe one leaf
	initial begin
		int               i;
		int               k;
		int               occupied;
		int               pick;
		int               leaf;
		int               roll;
		logic             op;
		logic [TID_W-1:0] tid;
		logic [LEAVES-1:0] leaf_mask;

		arst_n    <= 1'b0;
		in_valid  <= 1'b0;
		cmd       <= CMD_ARRIVE;
		thread_id <= '0;
		for (k = 0; k < NODE_TOTAL; k++) tree_counts[k] = '0;
		tree_set     = 1'b0;
		tree_changes = '0;
		leaf_mask    = '1;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (i = 0; i < DIRECTED_ROWS; i++)
			send_request(directed_rows[i].cmd, directed_rows[i].tid,
				directed_rows[i].typed, directed_rows[i].want);

		for (i = 0; i < RANDOM_ITEMS; i++) begin
			if (i % 50 == 0) steady = ($urandom_range(3) == 0);
			if (i % 100 == 0) leaf_mask = LEAVES'($urandom_range(1, 2**LEAVES - 1));
			// keep the sender pressing while the receiver holds off
			if (i == 300) begin
				steady = 1'b1;
				backlog_req = 1'b1;
			end
			occupied = 0;
			for (k = 0; k < LEAVES; k++)
				if (tree_counts[LEAVES - 1 + k] != 0) occupied++;
			roll = $urandom_range(99);
			if (roll < 10) begin
				// noise: anything at all, departs at zero included
				op  = 1'($urandom_range(1));
				tid = TID_W'($urandom_range(2**TID_W - 1));
			end else begin
				if (occupied != 0 && roll < 57) begin
					op   = CMD_DEPART;
					pick = $urandom_range(occupied - 1);
					leaf = 0;
					for (k = 0; k < LEAVES; k++)
						if (tree_counts[LEAVES - 1 + k] != 0) begin
							if (pick == 0) leaf = k;
							pick--;
						end
				end else begin
					op = CMD_ARRIVE;
					do leaf = $urandom_range(LEAVES - 1); while (!leaf_mask[leaf]);
				end
				tid = TID_W'($urandom_range(2**(TID_W - LEAF_W) - 1) * LEAVES + leaf);
			end
			send_request(op, tid, 1'b0, '0);
		end

		// Hit one leaf, its aliases and a neighbour back to back
		steady = 1'b1;
		send_request(CMD_ARRIVE, TID_W'(PROBE_LEAF), 1'b0, '0);
		send_request(CMD_ARRIVE, TID_W'(PROBE_LEAF + LEAVES), 1'b0, '0);
		send_request(CMD_ARRIVE, TID_W'(PROBE_LEAF + 1), 1'b0, '0);
		send_request(CMD_DEPART, TID_W'(PROBE_LEAF), 1'b0, '0);
		send_request(CMD_ARRIVE, TID_W'(PROBE_LEAF), 1'b0, '0);
		send_request(CMD_ARRIVE, 10'h3ff - TID_W'(LEAVES - 1 - PROBE_LEAF), 1'b0, '0);
		in_valid <= 1'b0;
		steady = 1'b0;

		// Drain, then allow for any stray result
		while (pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	// Watchdog
	initial begin
		#8000000;
		$display("RESULT: ERROR");
		$finish;
	end

endmodule
